### hdl/assert_macros.svh
// assertion macros shared by the door sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked every clock, skipped while reset is high
`define DSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dss assertion failed");
// property checked every clock, reset included
`define DSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dss assertion failed");
`else
`define DSS_ASSERT(lbl, clk, rst, prop)
`define DSS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/dss_pkg.sv
// types and constants of the door servo sequencer
`timescale 1ns / 1ps
package dss_pkg;

  localparam int CFG_BITS = 24;
  localparam int STEP_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int COUNTER_BITS_DEF = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_SHORT     = 3'd1,
    REG_STAGE     = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_PULSE_MIN = 3'd4,
    REG_PULSE_MAX = 3'd5,
    REG_STEP      = 3'd6,
    REG_POLL      = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_BITS-1:0]  DEBOUNCE_RST  = 24'd80000;
  localparam logic [CFG_BITS-1:0]  SHORT_RST     = 24'd400000;
  localparam logic [CFG_BITS-1:0]  STAGE_RST     = 24'd4000000;
  localparam logic [CFG_BITS-1:0]  PERIOD_RST    = 24'd1600000;
  localparam logic [CFG_BITS-1:0]  PULSE_MIN_RST = 24'd56000;
  localparam logic [CFG_BITS-1:0]  PULSE_MAX_RST = 24'd120000;
  localparam logic [STEP_BITS-1:0] STEP_RST      = 16'd1000;
  localparam logic [CFG_BITS-1:0]  POLL_RST      = 24'd10000;

  typedef struct packed {
    logic [CFG_BITS-1:0]  debounce;
    logic [CFG_BITS-1:0]  short_delay;
    logic [CFG_BITS-1:0]  stage_delay;
    logic [CFG_BITS-1:0]  pwm_period;
    logic [CFG_BITS-1:0]  pulse_min;
    logic [CFG_BITS-1:0]  pulse_max;
    logic [STEP_BITS-1:0] pulse_step;
    logic [CFG_BITS-1:0]  poll_interval;
  } dss_cfg_t;

  typedef struct packed {
    logic servo_pulse;
    logic led_four;
    logic led_five;
    logic led_six;
    logic door_is_open;
  } dss_result_t;

endpackage

### hdl/dss_if.sv
// valid/ready channels for sensor samples and controller outputs
`timescale 1ns / 1ps
interface dss_in_if;
  logic valid;
  logic ready;
  logic presence;

  modport source (output valid, output presence, input ready);
  modport sink (input valid, input presence, output ready);
endinterface

interface dss_out_if;
  logic valid;
  logic ready;
  logic servo_pulse;
  logic led_four;
  logic led_five;
  logic led_six;
  logic door_is_open;

  modport source (output valid, output servo_pulse, output led_four, output led_five,
                  output led_six, output door_is_open, input ready);
  modport sink (input valid, input servo_pulse, input led_four, input led_five,
                input led_six, input door_is_open, output ready);
endinterface

### hdl/dss_core.sv
// door sequencer state machine, one tick per advance
`timescale 1ns / 1ps
module dss_core #(
  parameter int CounterBits = dss_pkg::COUNTER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 presence,
  input  dss_pkg::dss_cfg_t    cfg,
  output dss_pkg::dss_result_t result_next
);
  import dss_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = CounterBits;
  localparam int SW = ((CW > CFG_BITS) ? CW : CFG_BITS) + 1;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_DEBOUNCE    = 4'd1,
    PH_SHORT_OPEN  = 4'd2,
    PH_STAGE5      = 4'd3,
    PH_STAGE6      = 4'd4,
    PH_SWEEP_UP    = 4'd5,
    PH_POLL        = 4'd6,
    PH_CLOSE_WAIT  = 4'd7,
    PH_SWEEP_DOWN  = 4'd8,
    PH_SHORT_CLOSE = 4'd9
  } phase_t;

  // led bit positions
  localparam int L4 = 0;
  localparam int L5 = 1;
  localparam int L6 = 2;

  phase_t         phase, phase_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  width, width_next;
  logic           pulse_high, pulse_high_next;
  logic [2:0]     led, led_next;
  logic           open_flag, open_flag_next;

  logic [SW-1:0]  step_ext, w_ext, up_w, dn_w, period_ext, low_diff;
  logic           up_ok, dn_ok, sweep_empty;
  logic [CW-1:0]  low_len;

  function automatic logic [CW-1:0] fit(input logic [CFG_BITS-1:0] v);
    logic [SW-1:0] t;
    t = SW'(v);
    return t[CW-1:0];
  endfunction

  // sweep arithmetic, wide enough that nothing wraps
  assign step_ext    = (cfg.pulse_step == '0) ? SW'(1) : SW'(cfg.pulse_step);
  assign w_ext       = SW'(width);
  assign up_w        = w_ext + step_ext;
  assign dn_w        = w_ext - step_ext;
  assign up_ok       = up_w <= SW'(cfg.pulse_max);
  assign dn_ok       = (w_ext >= step_ext) && (dn_w >= SW'(cfg.pulse_min));
  assign period_ext  = SW'(cfg.pwm_period);
  assign low_diff    = period_ext - w_ext;
  assign low_len     = (period_ext > w_ext) ? low_diff[CW-1:0] : CW'(1);
  assign sweep_empty = cfg.pulse_min > cfg.pulse_max;

  always_comb begin
    phase_next      = phase;
    cnt_next        = cnt;
    width_next      = width;
    pulse_high_next = pulse_high;
    led_next        = led;
    open_flag_next  = open_flag;
    priority if (phase == PH_IDLE) begin
      if (presence) begin
        phase_next = PH_DEBOUNCE;
        cnt_next   = fit(cfg.debounce);
      end
    end else if (phase > PH_SHORT_CLOSE) begin
      phase_next      = PH_IDLE;
      pulse_high_next = 1'b0;
    end else if (cnt > CW'(1)) begin
      cnt_next = cnt - CW'(1);
    end else begin
      unique case (phase)
        PH_DEBOUNCE: begin
          led_next[L4]   = 1'b0;
          open_flag_next = 1'b1;
          phase_next     = PH_SHORT_OPEN;
          cnt_next       = fit(cfg.short_delay);
        end
        PH_SHORT_OPEN: begin
          led_next[L5] = 1'b1;
          phase_next   = PH_STAGE5;
          cnt_next     = fit(cfg.stage_delay);
        end
        PH_STAGE5: begin
          led_next[L6] = 1'b1;
          phase_next   = PH_STAGE6;
          cnt_next     = fit(cfg.stage_delay);
        end
        PH_STAGE6: begin
          if (sweep_empty) begin
            pulse_high_next = 1'b0;
            phase_next      = PH_POLL;
            cnt_next        = CW'(1);
          end else begin
            width_next      = fit(cfg.pulse_min);
            pulse_high_next = 1'b1;
            led_next        = '0;
            phase_next      = PH_SWEEP_UP;
            cnt_next        = fit(cfg.pulse_min);
          end
        end
        PH_SWEEP_UP: begin
          if (pulse_high) begin
            pulse_high_next = 1'b0;
            cnt_next        = low_len;
          end else if (up_ok) begin
            width_next      = up_w[CW-1:0];
            pulse_high_next = 1'b1;
            led_next        = '0;
            cnt_next        = up_w[CW-1:0];
          end else begin
            pulse_high_next = 1'b0;
            phase_next      = PH_POLL;
            cnt_next        = CW'(1);
          end
        end
        PH_POLL: begin
          if (!presence) begin
            led_next[L6] = 1'b1;
            led_next[L4] = 1'b1;
            phase_next   = PH_CLOSE_WAIT;
            cnt_next     = fit(cfg.stage_delay);
          end else begin
            cnt_next = fit(cfg.poll_interval);
          end
        end
        PH_CLOSE_WAIT: begin
          if (sweep_empty) begin
            pulse_high_next = 1'b0;
            open_flag_next  = 1'b0;
            led_next[L4]    = 1'b1;
            phase_next      = PH_SHORT_CLOSE;
            cnt_next        = fit(cfg.short_delay);
          end else begin
            width_next      = fit(cfg.pulse_max);
            pulse_high_next = 1'b1;
            led_next        = '0;
            phase_next      = PH_SWEEP_DOWN;
            cnt_next        = fit(cfg.pulse_max);
          end
        end
        PH_SWEEP_DOWN: begin
          if (pulse_high) begin
            pulse_high_next = 1'b0;
            cnt_next        = low_len;
          end else if (dn_ok) begin
            width_next      = dn_w[CW-1:0];
            pulse_high_next = 1'b1;
            led_next        = '0;
            cnt_next        = dn_w[CW-1:0];
          end else begin
            pulse_high_next = 1'b0;
            open_flag_next  = 1'b0;
            led_next[L4]    = 1'b1;
            phase_next      = PH_SHORT_CLOSE;
            cnt_next        = fit(cfg.short_delay);
          end
        end
        default: begin
          // end of short closing delay
          phase_next = PH_IDLE;
          cnt_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      cnt        <= '0;
      width      <= '0;
      pulse_high <= 1'b0;
      led        <= '0;
      open_flag  <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      cnt        <= cnt_next;
      width      <= width_next;
      pulse_high <= pulse_high_next;
      led        <= led_next;
      open_flag  <= open_flag_next;
    end
  end

  assign result_next.servo_pulse  = pulse_high_next;
  assign result_next.led_four     = led_next[L4];
  assign result_next.led_five     = led_next[L5];
  assign result_next.led_six      = led_next[L6];
  assign result_next.door_is_open = open_flag_next;

  `DSS_ASSERT(a_pulse_in_sweep, clk, rst,
              pulse_high |-> (phase == PH_SWEEP_UP || phase == PH_SWEEP_DOWN))
  `DSS_ASSERT(a_closed_before_open, clk, rst,
              (phase == PH_IDLE || phase == PH_DEBOUNCE) |-> !open_flag)
  `DSS_ASSERT(a_idle_holds, clk, rst,
              (advance && phase == PH_IDLE && !presence) |=> (phase == PH_IDLE))

endmodule

### hdl/door_servo_sequencer.sv
// top level of the door servo sequencer: config registers, input and output stages
//
//  channel   dir  transfer payload                       notes
//  sensor    in   presence (1)                           one sample per timing tick
//  status    out  servo_pulse, led_four/five/six,        one result per sample
//                 door_is_open (1 each)
//  cfg       in   cfg_we, cfg_index (3), cfg_data (24)   write only, taken every edge
//
// one sample per cycle sustained while status is ready; a sample passes the input stage, then the result register
// the whole tick update is one pass of the state machine between the two stages
// a stalled result holds in its register while one more sample waits in the input stage
// synchronous reset clears the state machine and loads the register defaults
`timescale 1ns / 1ps
module door_servo_sequencer #(
  parameter int COUNTER_BITS = dss_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  dss_in_if.sink                            sensor,
  dss_out_if.source                         status,
  input  logic                              cfg_we,
  input  logic [dss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [dss_pkg::CFG_BITS-1:0]      cfg_data
);
  import dss_pkg::*;
  `include "assert_macros.svh"

  dss_cfg_t    cfg;
  dss_result_t result_next, result_q;
  logic        stage_valid, stage_presence;
  logic        out_valid;
  logic        advance, take;
  cfg_reg_t    cfg_sel;

  assign cfg_sel = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce      <= DEBOUNCE_RST;
      cfg.short_delay   <= SHORT_RST;
      cfg.stage_delay   <= STAGE_RST;
      cfg.pwm_period    <= PERIOD_RST;
      cfg.pulse_min     <= PULSE_MIN_RST;
      cfg.pulse_max     <= PULSE_MAX_RST;
      cfg.pulse_step    <= STEP_RST;
      cfg.poll_interval <= POLL_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_DEBOUNCE:  cfg.debounce      <= cfg_data;
        REG_SHORT:     cfg.short_delay   <= cfg_data;
        REG_STAGE:     cfg.stage_delay   <= cfg_data;
        REG_PERIOD:    cfg.pwm_period    <= cfg_data;
        REG_PULSE_MIN: cfg.pulse_min     <= cfg_data;
        REG_PULSE_MAX: cfg.pulse_max     <= cfg_data;
        REG_STEP:      cfg.pulse_step    <= cfg_data[STEP_BITS-1:0];
        REG_POLL:      cfg.poll_interval <= cfg_data;
        default:       cfg.poll_interval <= cfg.poll_interval;
      endcase
    end
  end

  // sample moves into the result register when that register is free or drained
  assign advance      = stage_valid && (!out_valid || status.ready);
  assign sensor.ready = !stage_valid || advance;
  assign take         = sensor.valid && sensor.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      stage_valid <= take || (stage_valid && !advance);
      if (advance) begin
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_presence <= sensor.presence;
    end
    if (advance) begin
      result_q <= result_next;
    end
  end

  dss_core #(
    .CounterBits (COUNTER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .presence    (stage_presence),
    .cfg         (cfg),
    .result_next (result_next)
  );

  assign status.valid        = out_valid;
  assign status.servo_pulse  = result_q.servo_pulse;
  assign status.led_four     = result_q.led_four;
  assign status.led_five     = result_q.led_five;
  assign status.led_six      = result_q.led_six;
  assign status.door_is_open = result_q.door_is_open;

  `DSS_ASSERT(a_no_take_when_full, clk, rst,
              (stage_valid && out_valid && !status.ready) |-> !sensor.ready)
  `DSS_ASSERT(a_take_fills_stage, clk, rst, take |=> stage_valid)
  `DSS_ASSERT(a_result_drops_on_transfer, clk, rst,
              $fell(out_valid) |-> $past(status.ready))

endmodule

### sim/door_servo_sequencer_tb.sv
// self-checking bench for the door servo sequencer: sensor samples in, status transfers checked
`timescale 1ns / 1ps
module door_servo_sequencer_tb;
  import dss_pkg::*;

  typedef enum logic [3:0] {
    DP_IDLE, DP_DEBOUNCE, DP_SHORT_OPEN, DP_STAGE5, DP_STAGE6,
    DP_SWEEP_UP, DP_POLL, DP_CLOSE_WAIT, DP_SWEEP_DOWN, DP_SHORT_CLOSE
  } door_phase_t;

  localparam logic [2:0] LED4_M = 3'b001;
  localparam logic [2:0] LED5_M = 3'b010;
  localparam logic [2:0] LED6_M = 3'b100;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int SEGMENTS = 9;
  localparam int SEGMENT_ITEMS = 56;

  typedef struct {
    bit          is_write;
    cfg_reg_t    idx;
    logic [23:0] data;
    logic        presence;
    int          reps;
    bit          lit_on;
    dss_result_t lit;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  dss_in_if sensor_ch ();
  dss_out_if status_ch ();

  door_servo_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .sensor    (sensor_ch),
    .status    (status_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  door_phase_t door_ph;
  logic [23:0] tick_cnt;
  logic [23:0] servo_width;
  logic        servo_high;
  logic [2:0]  led_q;
  logic        open_q;
  dss_cfg_t    door_cfg;

  dss_result_t status_due_q [$];
  int fault_count = 0;
  int send_idle_pct = 32;
  int sink_idle_pct = 52;
  bit hold_request = 1'b0;
  logic [23:0] knob [8];

  // reset rows expect all zero; zero debounce opens on the very next sample
  plan_row_t door_plan [13] = '{
    '{1'b0, REG_DEBOUNCE,  24'd0, 1'b0, 3,  1'b1, 5'b00000},
    '{1'b1, REG_DEBOUNCE,  24'd0, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b1, REG_SHORT,     24'd1, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b1, REG_STAGE,     24'd1, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b1, REG_PERIOD,    24'd3, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b1, REG_PULSE_MIN, 24'd1, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b1, REG_PULSE_MAX, 24'd2, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b1, REG_STEP,      24'd0, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b1, REG_POLL,      24'd1, 1'b0, 0,  1'b0, 5'b00000},
    '{1'b0, REG_DEBOUNCE,  24'd0, 1'b1, 1,  1'b1, 5'b00000},
    '{1'b0, REG_DEBOUNCE,  24'd0, 1'b1, 1,  1'b1, 5'b00001},
    '{1'b0, REG_DEBOUNCE,  24'd0, 1'b1, 11, 1'b0, 5'b00000},
    '{1'b0, REG_DEBOUNCE,  24'd0, 1'b0, 9,  1'b0, 5'b00000}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function void arm_wait(door_phase_t nxt, logic [23:0] ticks);
    door_ph = nxt;
    tick_cnt = ticks;
  endfunction

  function void launch_pulse(door_phase_t sweep_ph, logic [23:0] width);
    servo_width = width;
    servo_high = 1'b1;
    led_q = '0;
    arm_wait(sweep_ph, width);
  endfunction

  function void end_sweep(bit upward);
    servo_high = 1'b0;
    if (upward) begin
      arm_wait(DP_POLL, 24'd1);
    end else begin
      open_q = 1'b0;
      led_q |= LED4_M;
      arm_wait(DP_SHORT_CLOSE, door_cfg.short_delay);
    end
  endfunction

  function void begin_sweep(bit upward);
    if (door_cfg.pulse_min > door_cfg.pulse_max) end_sweep(upward);
    else if (upward) launch_pulse(DP_SWEEP_UP, door_cfg.pulse_min);
    else launch_pulse(DP_SWEEP_DOWN, door_cfg.pulse_max);
  endfunction

  function void servo_tick(bit upward);
    logic [24:0] stride;
    logic [24:0] width;
    logic [24:0] nxt_w;
    stride = (door_cfg.pulse_step == '0) ? 25'd1 : {9'd0, door_cfg.pulse_step};
    width = {1'b0, servo_width};
    if (servo_high) begin
      // high time over, hold low for the rest of the period
      servo_high = 1'b0;
      arm_wait(door_ph, (door_cfg.pwm_period > servo_width) ?
               door_cfg.pwm_period - servo_width : 24'd1);
    end else if (upward) begin
      nxt_w = width + stride;
      if (nxt_w <= {1'b0, door_cfg.pulse_max}) launch_pulse(DP_SWEEP_UP, nxt_w[23:0]);
      else end_sweep(1'b1);
    end else begin
      nxt_w = width - stride;
      if (width >= stride && nxt_w >= {1'b0, door_cfg.pulse_min}) begin
        launch_pulse(DP_SWEEP_DOWN, nxt_w[23:0]);
      end else begin
        end_sweep(1'b0);
      end
    end
  endfunction

  function dss_result_t door_tick(logic present);
    dss_result_t r;
    if (door_ph == DP_IDLE) begin
      if (present) arm_wait(DP_DEBOUNCE, door_cfg.debounce);
    end else if (tick_cnt > 24'd1) begin
      tick_cnt = tick_cnt - 24'd1;
    end else begin
      case (door_ph)
        DP_DEBOUNCE: begin
          led_q &= ~LED4_M;
          open_q = 1'b1;
          arm_wait(DP_SHORT_OPEN, door_cfg.short_delay);
        end
        DP_SHORT_OPEN: begin
          led_q |= LED5_M;
          arm_wait(DP_STAGE5, door_cfg.stage_delay);
        end
        DP_STAGE5: begin
          led_q |= LED6_M;
          arm_wait(DP_STAGE6, door_cfg.stage_delay);
        end
        DP_STAGE6: begin_sweep(1'b1);
        DP_SWEEP_UP: servo_tick(1'b1);
        DP_POLL: begin
          if (!present) begin
            led_q |= LED6_M | LED4_M;
            arm_wait(DP_CLOSE_WAIT, door_cfg.stage_delay);
          end else begin
            arm_wait(DP_POLL, door_cfg.poll_interval);
          end
        end
        DP_CLOSE_WAIT: begin_sweep(1'b0);
        DP_SWEEP_DOWN: servo_tick(1'b0);
        DP_SHORT_CLOSE: arm_wait(DP_IDLE, 24'd0);
        default: door_ph = DP_IDLE;
      endcase
    end
    r.servo_pulse = servo_high;
    r.led_four = led_q[0];
    r.led_five = led_q[1];
    r.led_six = led_q[2];
    r.door_is_open = open_q;
    return r;
  endfunction

  function void fill_knobs(logic [23:0] d, logic [23:0] s, logic [23:0] t, logic [23:0] p,
                           logic [23:0] lo, logic [23:0] hi, logic [23:0] st,
                           logic [23:0] pl);
    knob[REG_DEBOUNCE] = d;
    knob[REG_SHORT] = s;
    knob[REG_STAGE] = t;
    knob[REG_PERIOD] = p;
    knob[REG_PULSE_MIN] = lo;
    knob[REG_PULSE_MAX] = hi;
    knob[REG_STEP] = st;
    knob[REG_POLL] = pl;
  endfunction

  task automatic note_fault(input string what, input dss_result_t want, input dss_result_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t %s: exp servo=%b led4=%b led5=%b led6=%b open=%b,",
               $time, what, want.servo_pulse, want.led_four, want.led_five, want.led_six,
               want.door_is_open);
      $display("    got servo=%b led4=%b led5=%b led6=%b open=%b",
               got.servo_pulse, got.led_four, got.led_five, got.led_six,
               got.door_is_open);
    end
  endtask

  // registers only change once every status transfer has come back
  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    sensor_ch.valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:  door_cfg.debounce = val;
      REG_SHORT:     door_cfg.short_delay = val;
      REG_STAGE:     door_cfg.stage_delay = val;
      REG_PERIOD:    door_cfg.pwm_period = val;
      REG_PULSE_MIN: door_cfg.pulse_min = val;
      REG_PULSE_MAX: door_cfg.pulse_max = val;
      REG_STEP:      door_cfg.pulse_step = val[STEP_BITS-1:0];
      REG_POLL:      door_cfg.poll_interval = val;
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic p, input bit lit_on, input dss_result_t lit);
    dss_result_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sensor_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sensor_ch.valid <= 1'b1;
    sensor_ch.presence <= p;
    @(posedge clk);
    while (!sensor_ch.ready) @(posedge clk);
    due = door_tick(p);
    status_due_q.push_back(lit_on ? lit : due);
  endtask

  initial begin : status_sink
    int hold_left;
    dss_result_t got;
    dss_result_t want;
    hold_left = 0;
    status_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (status_ch.valid && status_ch.ready) begin
        got.servo_pulse = status_ch.servo_pulse;
        got.led_four = status_ch.led_four;
        got.led_five = status_ch.led_five;
        got.led_six = status_ch.led_six;
        got.door_is_open = status_ch.door_is_open;
        if (status_due_q.size() == 0) begin
          note_fault("unexpected transfer", got, got);
        end else begin
          want = status_due_q.pop_front();
          if (got.servo_pulse !== want.servo_pulse || got.led_four !== want.led_four ||
              got.led_five !== want.led_five || got.led_six !== want.led_six ||
              got.door_is_open !== want.door_is_open) begin
            note_fault("mismatch", want, got);
          end
        end
      end
      if (hold_request) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic level;
    int run_left;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= '0;
    sensor_ch.valid <= 1'b0;
    sensor_ch.presence <= 1'b0;
    door_cfg.debounce = DEBOUNCE_RST;
    door_cfg.short_delay = SHORT_RST;
    door_cfg.stage_delay = STAGE_RST;
    door_cfg.pwm_period = PERIOD_RST;
    door_cfg.pulse_min = PULSE_MIN_RST;
    door_cfg.pulse_max = PULSE_MAX_RST;
    door_cfg.pulse_step = STEP_RST;
    door_cfg.poll_interval = POLL_RST;
    door_ph = DP_IDLE;
    tick_cnt = '0;
    servo_width = '0;
    servo_high = 1'b0;
    led_q = '0;
    open_q = 1'b0;
    level = 1'b0;
    run_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (door_plan[r]) begin
      if (door_plan[r].is_write) begin
        write_reg(door_plan[r].idx, door_plan[r].data);
      end else begin
        repeat (door_plan[r].reps)
          send_sample(door_plan[r].presence, door_plan[r].lit_on, door_plan[r].lit);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 32;
        sink_idle_pct = 52;
      end else if (seg < 6) begin
        send_idle_pct = 52;
        sink_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case (seg)
        0: fill_knobs(24'd3, 24'd2, 24'd4, 24'd10, 24'd2, 24'd8, 24'd3, 24'd2);
        // minimum above maximum: sweeps send no pulses
        1: fill_knobs(24'd1, 24'd1, 24'd2, 24'd2, 24'hFFFFFF, 24'd5, 24'd1, 24'd1);
        // zero period, step masked down to 16 bits, one pulse per sweep
        2: fill_knobs(24'd2, 24'd1, 24'd3, 24'd0, 24'd0, 24'd40, 24'hFFFFFF, 24'd3);
        // zero waits and zero step, pulses wider than the period
        3: fill_knobs(24'd0, 24'd0, 24'd0, 24'd6, 24'd1, 24'd8, 24'd0, 24'd0);
        default: fill_knobs(24'($urandom_range(0, 6)), 24'($urandom_range(0, 6)),
                            24'($urandom_range(0, 8)), 24'($urandom_range(0, 16)),
                            24'($urandom_range(0, 10)), 24'($urandom_range(0, 16)),
                            24'($urandom_range(0, 5)), 24'($urandom_range(0, 6)));
      endcase
      for (int k = 0; k < 8; k++) write_reg(cfg_reg_t'(k), knob[k[2:0]]);
      if (seg == 1) hold_request = 1'b1;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // presence held in runs so the door goes through whole cycles, short runs are glitches
        if (run_left == 0) begin
          level = ~level;
          run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) :
                     $urandom_range(5, 40);
        end
        run_left--;
        send_sample(level, 1'b0, 5'b00000);
      end
    end

    sensor_ch.valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
